// ===== sv/fcd_pkg.sv =====
`timescale 1ns / 1ps
// fcd_pkg: shared types and constants for the centroid defuzzifier
// no dependencies; used by fcd_controller, fcd_datapath and the top level

package fcd_pkg;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGLE   = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam int POS_W   = 32;
    localparam int GRADE_W = 17;
    localparam int ACC_W   = 64;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SEG    = 11'b000_0000_0010,
        S_AREA   = 11'b000_0000_0100,
        S_MLO    = 11'b000_0000_1000,
        S_MHI    = 11'b000_0001_0000,
        S_TERM   = 11'b000_0010_0000,
        S_ACC    = 11'b000_0100_0000,
        S_NEXT   = 11'b000_1000_0000,
        S_DIVS   = 11'b001_0000_0000,
        S_DIV    = 11'b010_0000_0000,
        S_RESULT = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic seg;
        logic area;
        logic mlo;
        logic mhi;
        logic term;
        logic acc;
        logic advance;
        logic div_start;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic last_in;
        logic last_reg;
        logic area_zero;
        logic div_done;
        logic out_busy;
    } stat_t;

endpackage

// ===== sv/fuzzy_centroid_defuzzifier.sv =====
`timescale 1ns / 1ps
// fuzzy_centroid_defuzzifier: top level, centroid of a discrete fuzzy set
// depends on fcd_pkg, fcd_controller, fcd_datapath
//
// usage
//   input stream: one point per transaction, position and grade in s_axis_tdata,
//   s_axis_tlast marks the last point of a set; points come in ascending order
//   output stream: one transaction per set, centroid in m_axis_tdata and the
//   status code in m_axis_tuser (ok, single point, zero area, overflow)
//   pacing: a point is taken only after the previous one has walked through
//   the chain of three registered multiplies and two 64-bit accumulations; the
//   first point of a set skips that chain
//   result: m_axis_tvalid rises after the last point has passed that chain and
//   the 64-step radix-2 divider for moment / area; the divider is skipped when
//   the area is zero, and a single-point set goes straight to the output register
//   reset: clears the running sums and the output valid flag, s_axis_tready is
//   high right after reset
//   stall: a finished result waits in the output register; the block keeps
//   taking points of the next set and only holds back a second result until the
//   first one has gone out

module fuzzy_centroid_defuzzifier
#(
    parameter int GRADE_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // position[31:0], grade[48:32], zero fill
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // centroid[31:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    fcd_pkg::cmd_t  cmd;
    fcd_pkg::stat_t st;

    fcd_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fcd_datapath
    #(
        .GRADE_FRAC_BITS (GRADE_FRAC_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .position    (s_axis_tdata[31:0]),
        .grade       (s_axis_tdata[48:32]),
        .final_point (s_axis_tlast),
        .cmd         (cmd),
        .st          (st),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .centroid    (m_axis_tdata),
        .status      (m_axis_tuser)
    );

endmodule

// ===== sv/fcd_controller.sv =====
`timescale 1ns / 1ps
// fcd_controller: sequencer for one point per pass and the final divide
// depends on fcd_pkg

module fcd_controller
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fcd_pkg::stat_t st,
    output fcd_pkg::cmd_t  cmd
);

    fcd_pkg::state_t state_reg;
    fcd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            fcd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (st.have_prev)
                    begin
                        state_next = fcd_pkg::S_SEG;
                    end
                    else if (st.last_in)
                    begin
                        state_next = fcd_pkg::S_RESULT;
                    end
                    else
                    begin
                        state_next = fcd_pkg::S_NEXT;
                    end
                end
            end
            fcd_pkg::S_SEG:
            begin
                cmd.seg    = 1'b1;
                state_next = fcd_pkg::S_AREA;
            end
            fcd_pkg::S_AREA:
            begin
                cmd.area   = 1'b1;
                state_next = fcd_pkg::S_MLO;
            end
            fcd_pkg::S_MLO:
            begin
                cmd.mlo    = 1'b1;
                state_next = fcd_pkg::S_MHI;
            end
            fcd_pkg::S_MHI:
            begin
                cmd.mhi    = 1'b1;
                state_next = fcd_pkg::S_TERM;
            end
            fcd_pkg::S_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = fcd_pkg::S_ACC;
            end
            fcd_pkg::S_ACC:
            begin
                cmd.acc = 1'b1;
                if (!st.last_reg)
                begin
                    state_next = fcd_pkg::S_NEXT;
                end
                else
                begin
                    state_next = fcd_pkg::S_DIVS;
                end
            end
            fcd_pkg::S_NEXT:
            begin
                cmd.advance = 1'b1;
                state_next  = fcd_pkg::S_IDLE;
            end
            fcd_pkg::S_DIVS:
            begin
                // zero area needs no quotient
                if (st.area_zero)
                begin
                    state_next = fcd_pkg::S_RESULT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = fcd_pkg::S_DIV;
                end
            end
            fcd_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = fcd_pkg::S_RESULT;
                end
            end
            fcd_pkg::S_RESULT:
            begin
                if (!st.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = fcd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fcd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/fcd_datapath.sv =====
`timescale 1ns / 1ps
// fcd_datapath: segment multiplies, saturating sums, radix-2 divider, output register
// depends on fcd_pkg; driven by fcd_controller

module fcd_datapath
#(
    parameter int GRADE_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fcd_pkg::POS_W-1:0]     position,
    input  logic [fcd_pkg::GRADE_W-1:0]   grade,
    input  logic                          final_point,
    input  fcd_pkg::cmd_t                 cmd,
    output fcd_pkg::stat_t                st,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [fcd_pkg::POS_W-1:0]     centroid,
    output logic [1:0]                    status
);

    localparam int AW  = fcd_pkg::ACC_W;
    localparam int PW  = 52;                       // 33-bit width times 19-bit grade sum
    localparam int SH  = GRADE_FRAC_BITS + 1;
    localparam int TW  = PW - SH;
    localparam int LW  = TW + 17;
    localparam int HW  = TW + 16;
    localparam int CW  = ((GRADE_FRAC_BITS > fcd_pkg::GRADE_W) ?
                          GRADE_FRAC_BITS : fcd_pkg::GRADE_W) + 1;

    function automatic logic [AW:0] sat_add(input logic signed [AW-1:0] a,
                                            input logic signed [AW-1:0] b);
        logic [AW-1:0] r;
        logic          ovf;
        r   = a + b;
        ovf = (a[AW-1] == b[AW-1]) && (r[AW-1] != a[AW-1]);
        if (ovf)
        begin
            r = a[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
        return {ovf, r};
    endfunction

    // input point
    logic signed [31:0] x_reg;
    logic [16:0]        g_reg;
    logic               last_reg;

    // accumulation state
    logic signed [31:0]    prev_pos_reg, prev_pos_next;
    logic [16:0]           prev_g_reg, prev_g_next;
    logic                  have_prev_reg, have_prev_next;
    logic signed [AW-1:0]  area_reg, area_next;
    logic signed [AW-1:0]  moment_reg, moment_next;
    logic                  ovf_reg, ovf_next;

    // segment pipeline
    logic signed [PW-1:0]  prod_reg;
    logic signed [TW-1:0]  t_reg;
    logic signed [31:0]    m_reg;
    logic signed [LW-1:0]  pplo_reg;
    logic signed [HW-1:0]  pphi_reg;
    logic signed [AW-1:0]  term_reg;

    // divider
    logic [AW-1:0]            rem_reg;
    logic [AW-1:0]            quo_reg;
    logic [AW-1:0]            den_reg;
    logic [fcd_pkg::DIV_CNT_W-1:0] cnt_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] cen_reg;
    logic [1:0]  stat_reg;

    // grade clamp to one
    logic [CW-1:0] g_ext;
    logic [CW-1:0] one_c;
    logic [16:0]   g_clamped;

    assign g_ext     = CW'(grade);
    assign one_c     = CW'(1) << GRADE_FRAC_BITS;
    assign g_clamped = (g_ext > one_c) ? one_c[16:0] : grade;

    // segment arithmetic
    logic signed [32:0]   h;
    logic [17:0]          sumg;
    logic signed [PW-1:0] prod_next;
    logic signed [32:0]   pos_sum;
    logic signed [TW-1:0] t_next;
    logic signed [LW-1:0] pplo_next;
    logic signed [HW-1:0] pphi_next;
    logic [AW:0]          area_add;
    logic [AW:0]          moment_add;

    assign h         = {x_reg[31], x_reg} - {prev_pos_reg[31], prev_pos_reg};
    assign sumg      = {1'b0, prev_g_reg} + {1'b0, g_reg};
    assign prod_next = h * $signed({1'b0, sumg});
    assign pos_sum   = {x_reg[31], x_reg} + {prev_pos_reg[31], prev_pos_reg};
    // floor shift is the upper part of the product
    assign t_next    = $signed(prod_reg[PW-1:SH]);
    assign pplo_next = t_reg * $signed({1'b0, m_reg[15:0]});
    assign pphi_next = t_reg * $signed(m_reg[31:16]);
    assign area_add   = sat_add(area_reg, AW'(t_next));
    assign moment_add = sat_add(moment_reg, term_reg);

    // divider step
    logic [AW:0]   trial;
    logic          fits;
    logic [AW-1:0] mag_num;
    logic [AW-1:0] mag_den;

    assign mag_num = moment_reg[AW-1] ? (AW'(0) - moment_reg) : moment_reg;
    assign mag_den = area_reg[AW-1] ? (AW'(0) - area_reg) : area_reg;
    assign trial   = {rem_reg, quo_reg[AW-1]};
    assign fits    = trial >= {1'b0, den_reg};

    // result selection
    logic        neg;
    logic [31:0] res_c;
    logic [1:0]  res_s;

    always_comb
    begin
        neg   = moment_reg[AW-1] ^ area_reg[AW-1];
        res_c = '0;
        res_s = fcd_pkg::ST_OK;
        if (!have_prev_reg)
        begin
            res_c = x_reg;
            res_s = fcd_pkg::ST_SINGLE;
        end
        else if (area_reg == '0)
        begin
            res_c = '0;
            res_s = ovf_reg ? fcd_pkg::ST_OVERFLOW : fcd_pkg::ST_ZERO;
        end
        else
        begin
            res_s = ovf_reg ? fcd_pkg::ST_OVERFLOW : fcd_pkg::ST_OK;
            if (neg)
            begin
                if (quo_reg > AW'(64'h8000_0000))
                begin
                    res_c = 32'h8000_0000;
                    res_s = fcd_pkg::ST_OVERFLOW;
                end
                else
                begin
                    res_c = 32'(0) - quo_reg[31:0];
                end
            end
            else
            begin
                if (quo_reg > AW'(64'h7FFF_FFFF))
                begin
                    res_c = 32'h7FFF_FFFF;
                    res_s = fcd_pkg::ST_OVERFLOW;
                end
                else
                begin
                    res_c = quo_reg[31:0];
                end
            end
        end
    end

    // accumulation state next values
    always_comb
    begin
        prev_pos_next  = prev_pos_reg;
        prev_g_next    = prev_g_reg;
        have_prev_next = have_prev_reg;
        area_next      = area_reg;
        moment_next    = moment_reg;
        ovf_next       = ovf_reg;
        if (cmd.area)
        begin
            area_next = area_add[AW-1:0];
            ovf_next  = ovf_reg | area_add[AW];
        end
        if (cmd.acc)
        begin
            moment_next = moment_add[AW-1:0];
            ovf_next    = ovf_reg | moment_add[AW];
        end
        if (cmd.advance)
        begin
            prev_pos_next  = x_reg;
            prev_g_next    = g_reg;
            have_prev_next = 1'b1;
        end
        if (cmd.load_out)
        begin
            prev_pos_next  = '0;
            prev_g_next    = '0;
            have_prev_next = 1'b0;
            area_next      = '0;
            moment_next    = '0;
            ovf_next       = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg  <= '0;
            prev_g_reg    <= '0;
            have_prev_reg <= 1'b0;
            area_reg      <= '0;
            moment_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_pos_reg  <= prev_pos_next;
            prev_g_reg    <= prev_g_next;
            have_prev_reg <= have_prev_next;
            area_reg      <= area_next;
            moment_reg    <= moment_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg    <= position;
            g_reg    <= g_clamped;
            last_reg <= final_point;
        end
        if (cmd.seg)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.area)
        begin
            t_reg <= t_next;
            m_reg <= pos_sum[32:1];
        end
        if (cmd.mlo)
        begin
            pplo_reg <= pplo_next;
        end
        if (cmd.mhi)
        begin
            pphi_reg <= pphi_next;
        end
        if (cmd.term)
        begin
            // exact product t * m from the two partial products
            term_reg <= (AW'(pphi_reg) <<< 16) + AW'(pplo_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= mag_num;
            den_reg <= mag_den;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? AW'(trial - {1'b0, den_reg}) : trial[AW-1:0];
            quo_reg <= {quo_reg[AW-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            cen_reg  <= res_c;
            stat_reg <= res_s;
        end
    end

    assign st.have_prev = have_prev_reg;
    assign st.last_in   = final_point;
    assign st.last_reg  = last_reg;
    assign st.area_zero = (area_reg == '0);
    assign st.div_done  = (cnt_reg == {fcd_pkg::DIV_CNT_W{1'b1}});
    assign st.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign centroid  = cen_reg;
    assign status    = stat_reg;

endmodule

// ===== sv/fcd_checker.sv =====
`timescale 1ns / 1ps
// fcd_checker: port-level checks on the defuzzifier streams
// depends only on the top-level ports; bound to fuzzy_centroid_defuzzifier

module fcd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a result held by the receiver stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // every point is worked on before the next one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("point taken while the previous one is in flight");

    // no result is loaded while points are taken, so a sent result leaves the output empty
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && s_axis_tready |=> !m_axis_tvalid)
        else $error("result repeated");

endmodule

bind fuzzy_centroid_defuzzifier fcd_checker u_fcd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for fuzzy_centroid_defuzzifier, streams fuzzy sets point by point
// and compares every centroid and status against a fixed-point centroid predictor or a pinned value
// depends on fcd_pkg and fuzzy_centroid_defuzzifier

module tb_top;

    localparam int     ITEM_TARGET  = 700;
    localparam int     HOLD_AT      = 60;
    localparam int     HOLD_CYCLES  = 1500;
    localparam longint GRADE_ONE    = 64'sd65536;
    localparam longint POS_MAX      = 64'sd2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;
    localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN      = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [31:0] centroid;
        logic [1:0]  status;
    } centroid_result_t;

    typedef struct {
        logic [31:0] pos;
        logic [16:0] grade;
        bit          last;
        bit          pinned;
        logic [31:0] pin_c;
        logic [1:0]  pin_st;
    } point_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // running state of the centroid predictor
    longint      prev_pos;
    longint      prev_grade;
    bit          have_prev;
    longint      area_acc;
    longint      moment_acc;
    bit          sum_saturated;

    centroid_result_t pending_centroids[$];
    int          fail_count;
    int          points_sent;
    int          sets_sent;
    int          results_checked;
    int          status_count[4];
    int          send_idle_pct;
    int          stall_pct;
    int          hold_left;
    bit          hold_done;

    point_row_t  directed_rows[22];

    fuzzy_centroid_defuzzifier dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic longint add_saturating(input longint a, input longint b);
        longint r;
        r = a + b;
        if ((a < 0) == (b < 0) && (r < 0) != (a < 0))
        begin
            sum_saturated = 1'b1;
            return (a < 0) ? ACC_MIN : ACC_MAX;
        end
        return r;
    endfunction

    // folds one point into the running sums; returns 1 when the point closes a set
    function automatic bit fold_point(input longint x, input longint g_in, input bit last,
                                      output logic [31:0] c, output logic [1:0] st);
        longint g;
        longint seg_area;
        longint mid;
        logic [63:0] mag_m;
        logic [63:0] mag_a;
        logic [63:0] q;
        bit neg;
        g = (g_in > GRADE_ONE) ? GRADE_ONE : g_in;
        c = '0;
        st = fcd_pkg::ST_OK;
        if (have_prev)
        begin
            seg_area = ((x - prev_pos) * (prev_grade + g)) >>> 17;
            mid = (prev_pos + x) >>> 1;
            area_acc = add_saturating(area_acc, seg_area);
            moment_acc = add_saturating(moment_acc, seg_area * mid);
        end
        if (!last)
        begin
            prev_pos = x;
            prev_grade = g;
            have_prev = 1'b1;
            return 1'b0;
        end
        if (!have_prev)
        begin
            c = x[31:0];
            st = fcd_pkg::ST_SINGLE;
        end
        else if (area_acc == 0)
        begin
            st = sum_saturated ? fcd_pkg::ST_OVERFLOW : fcd_pkg::ST_ZERO;
        end
        else
        begin
            neg = (moment_acc < 0) != (area_acc < 0);
            mag_m = (moment_acc < 0) ? -moment_acc : moment_acc;
            mag_a = (area_acc < 0) ? -area_acc : area_acc;
            q = mag_m / mag_a;
            st = sum_saturated ? fcd_pkg::ST_OVERFLOW : fcd_pkg::ST_OK;
            if (neg)
            begin
                if (q > 64'h8000_0000)
                begin
                    q = 64'h8000_0000;
                    st = fcd_pkg::ST_OVERFLOW;
                end
                c = -q[31:0];
            end
            else
            begin
                if (q > 64'h7FFF_FFFF)
                begin
                    q = 64'h7FFF_FFFF;
                    st = fcd_pkg::ST_OVERFLOW;
                end
                c = q[31:0];
            end
        end
        prev_pos = 0;
        prev_grade = 0;
        have_prev = 1'b0;
        area_acc = 0;
        moment_acc = 0;
        sum_saturated = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [16:0] pick_grade();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 17'd0;
        if (r < 16)
            return 17'h10000;
        if (r < 21)
            return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_point(input logic signed [31:0] pos, input logic [16:0] grade,
                              input bit last, input bit pinned,
                              input logic [31:0] pin_c, input logic [1:0] pin_st);
        centroid_result_t want;
        logic [31:0] c;
        logic [1:0]  st;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, grade, pos};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        points_sent++;
        if (fold_point(longint'(pos), longint'(grade), last, c, st))
        begin
            sets_sent++;
            want.centroid = pinned ? pin_c : c;
            want.status   = pinned ? pin_st : st;
            pending_centroids.push_back(want);
        end
        @(negedge clk);
    endtask

    task automatic send_ascending_set(input int n);
        longint x;
        int span;
        int i;
        x = longint'($signed($urandom)) >>> $urandom_range(0, 12);
        span = $urandom_range(4, 28);
        for (i = 0; i < n; i++)
        begin
            send_point(x[31:0], pick_grade(), i == n - 1, 1'b0, '0, fcd_pkg::ST_OK);
            x = x + $urandom_range(0, 32'(1 << span));
            if (x > POS_MAX)
                x = POS_MAX;
        end
    endtask

    task automatic send_noise_set();
        int n;
        int i;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
            send_point($urandom, 17'($urandom_range(0, 131071)), i == n - 1, 1'b0, '0,
                       fcd_pkg::ST_OK);
    endtask

    // half-span segments from zero to one end, zero-grade returns, drives the moment sum toward saturation
    task automatic send_zigzag_set();
        longint lo;
        longint hi;
        int segs;
        int i;
        segs = $urandom_range(3, 7);
        if ($urandom_range(0, 1))
        begin
            lo = 0;
            hi = POS_MAX - $urandom_range(0, 255);
        end
        else
        begin
            lo = POS_MIN + $urandom_range(0, 255);
            hi = 0;
        end
        for (i = 0; i < segs; i++)
        begin
            send_point(lo[31:0], 17'h10000, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
            send_point(hi[31:0], 17'h10000, i == segs - 1, 1'b0, '0, fcd_pkg::ST_OK);
            if (i != segs - 1)
            begin
                send_point(hi[31:0], 17'd0, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
                send_point(lo[31:0], 17'd0, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
            end
        end
    endtask

    // tiny net area far from the origin, quotient leaves the 32-bit range
    task automatic send_steep_set();
        longint h;
        if ($urandom_range(0, 1))
            h = 64'sd1073741824 + $urandom_range(0, 32'h3FFF_FFFC);
        else
            h = POS_MIN + $urandom_range(0, 32'h3FFF_FFFE);
        send_point(h[31:0], 17'd0, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
        send_point(h[31:0], 17'h10000, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
        send_point(32'(h + 2), 17'h10000, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
        send_point(32'(h + 2), 17'd0, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
        send_point(32'd0, 17'd0, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
        send_point(32'd0, 17'h10000, 1'b0, 1'b0, '0, fcd_pkg::ST_OK);
        send_point(32'hFFFF_FFFF, 17'h10000, 1'b1, 1'b0, '0, fcd_pkg::ST_OK);
    endtask

    // receiver side, with one long hold-off while the sender keeps going
    always @(negedge clk)
    begin
        if (!hold_done && points_sent >= HOLD_AT)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        centroid_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_centroids.size() == 0)
            begin
                $error("centroid transaction with none pending: centroid %h status %0d",
                       m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_centroids.pop_front();
                results_checked++;
                status_count[m_axis_tuser]++;
                if (m_axis_tdata !== want.centroid)
                begin
                    $error("centroid: expected %h, got %h", want.centroid, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results still pending", pending_centroids.size());
        $display("fuzzy_centroid_defuzzifier: mismatch");
        $finish;
    end

    initial
    begin
        int phase;
        int pick;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        prev_pos = 0;
        prev_grade = 0;
        have_prev = 1'b0;
        area_acc = 0;
        moment_acc = 0;
        sum_saturated = 1'b0;
        fail_count = 0;
        points_sent = 0;
        sets_sent = 0;
        results_checked = 0;
        status_count = '{0, 0, 0, 0};
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        hold_done = 1'b0;

        directed_rows = '{
            // single points at both position extremes
            '{32'h7FFF_FFFF, 17'd0,     1'b1, 1'b1, 32'h7FFF_FFFF, fcd_pkg::ST_SINGLE},
            '{32'h8000_0000, 17'h10000, 1'b1, 1'b1, 32'h8000_0000, fcd_pkg::ST_SINGLE},
            // all grades zero
            '{32'h0064_0000, 17'd0,     1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h00C8_0000, 17'd0,     1'b1, 1'b1, 32'd0,         fcd_pkg::ST_ZERO},
            // repeated position, zero-width segment
            '{32'h0005_0000, 17'h10000, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h0005_0000, 17'h10000, 1'b1, 1'b1, 32'd0,         fcd_pkg::ST_ZERO},
            // symmetric triangle around 1.0
            '{32'h0000_0000, 17'd0,     1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h0001_0000, 17'h10000, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h0002_0000, 17'd0,     1'b1, 1'b1, 32'h0001_0000, fcd_pkg::ST_OK},
            // grades above one get clamped
            '{32'h0000_0000, 17'h1FFFF, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h0001_0000, 17'h1FFFF, 1'b1, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            // full position span
            '{32'h8000_0000, 17'h10000, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h7FFF_FFFF, 17'h10000, 1'b1, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            // descending pair, negative area
            '{32'h000A_0000, 17'h10000, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h0000_0000, 17'h08000, 1'b1, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            // net area of one far out, quotient saturates high
            '{32'h4000_0000, 17'd0,     1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h4000_0000, 17'h10000, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h4000_0002, 17'h10000, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h4000_0002, 17'd0,     1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h0000_0000, 17'd0,     1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'h0000_0000, 17'h10000, 1'b0, 1'b0, 32'd0,         fcd_pkg::ST_OK},
            '{32'hFFFF_FFFF, 17'h10000, 1'b1, 1'b1, 32'h7FFF_FFFF, fcd_pkg::ST_OVERFLOW}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_point(directed_rows[i].pos, directed_rows[i].grade, directed_rows[i].last,
                       directed_rows[i].pinned, directed_rows[i].pin_c, directed_rows[i].pin_st);

        while (points_sent < ITEM_TARGET)
        begin
            phase = (points_sent * 4) / ITEM_TARGET;
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_ascending_set(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                                : $urandom_range(2, 12));
            else if (pick < 72)
                send_noise_set();
            else if (pick < 82)
                send_zigzag_set();
            else if (pick < 92)
                send_steep_set();
            else
                send_ascending_set(1);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (pending_centroids.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d points in %0d sets, checked %0d centroid transactions",
                 points_sent, sets_sent, results_checked);
        $display("status seen: ok %0d, single point %0d, zero area %0d, saturated %0d",
                 status_count[fcd_pkg::ST_OK], status_count[fcd_pkg::ST_SINGLE],
                 status_count[fcd_pkg::ST_ZERO], status_count[fcd_pkg::ST_OVERFLOW]);
        if (fail_count == 0)
            $display("fuzzy_centroid_defuzzifier: match");
        else
            $display("fuzzy_centroid_defuzzifier: mismatch");
        $finish;
    end

endmodule
